FILE: rtl/core/ddo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the odometry block
// Holds the fixed-point format, the sequencer states, the multiplier control
// and status words, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // Fraction bits of the pose, heading and scale Q values.
  localparam int FRAC_BITS = 16;

  // Shared serial multiplier sizes.
  localparam int MA_W      = 64;
  localparam int MB_W      = 32;
  localparam int ACC_W     = MA_W + MB_W;
  localparam int MCNT_W    = 6;

  // Field widths of the stream words.
  localparam int TICK_W    = 32;
  localparam int POS_W     = 48;
  localparam int HDG_W     = 25;
  localparam int IN_DATA_W = 192;
  localparam int OUT_DATA_W = 128;

  // CORDIC constants: angle in Q.24 degrees, x and y in Q.30.
  localparam int TAB_LEN   = 24;
  localparam int IDX_W     = 5;
  localparam int ANG_W     = 34;
  localparam int XY_W      = 33;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ANG_W-1:0] D90_Q24 = 34'sd1509949440;

  // atan(2^-i) in degrees, Q.24.
  localparam logic [31:0] ATAN_Q24 [TAB_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // Configuration register indexes.
  localparam logic REG_DIST_SCALE = 1'b0;
  localparam logic REG_TURN_SCALE = 1'b1;

  // Input command codes.
  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_SET_POSE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TRAV_GO,
    S_TRAV_WAIT,
    S_TURN_GO,
    S_TURN_WAIT,
    S_WRAP,
    S_MOD,
    S_MRED,
    S_MFIX,
    S_CINIT,
    S_CORDIC,
    S_ROUND,
    S_X_GO,
    S_X_WAIT,
    S_Y_GO,
    S_Y_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [MCNT_W-1:0] nbits;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/ddo_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul: serial signed multiplier
// Shift-and-add over the bits of b, most significant first, one bit per
// cycle. The top bit of the selected range carries negative weight.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ddo_pkg::mul_ctl_t               ctl,
  input  wire logic signed [ddo_pkg::MA_W-1:0] a,
  input  wire logic signed [ddo_pkg::MB_W-1:0] b,
  output ddo_pkg::mul_sts_t                    sts,
  output logic signed [ddo_pkg::ACC_W-1:0]     prod
);
  import ddo_pkg::*;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [MA_W-1:0]  a_r, a_nxt;
  logic [MB_W-1:0]         b_r, b_nxt;
  logic [MCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    first_r, first_nxt;
  logic                    done_r, done_nxt;
  logic signed [ACC_W-1:0] addend;

  // One shift-add step per cycle.
  always_comb begin
    acc_nxt   = acc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    first_nxt = first_r;
    done_nxt  = 1'b0;
    addend    = '0;
    if (b_r[MB_W-1]) begin
      addend = first_r ? -ACC_W'(a_r) : ACC_W'(a_r);
    end
    if (ctl.start) begin
      acc_nxt   = '0;
      a_nxt     = a;
      b_nxt     = b << (MCNT_W'(MB_W) - ctl.nbits);
      cnt_nxt   = ctl.nbits;
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt   = (acc_r <<< 1) + addend;
      b_nxt     = b_r << 1;
      cnt_nxt   = cnt_r - 1'b1;
      first_nxt = 1'b0;
      if (cnt_r == MCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule
`default_nettype wire

FILE: rtl/core/differential_drive_odometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose tracker
// Integrates wheel encoder counts into x, y and heading for a two-wheel robot
// using a shared serial multiplier, a folding modulo-360 unit and a CORDIC loop.
// ----------------------------------------------------------------------------
// A sample word passes through the travel and turn multiplies, the heading wrap
//   (with a modulo-360 reduction when the heading leaves [-180,180]), the CORDIC
//   loop and the x and y multiplies before out_tvalid; a set-pose word only
//   through the heading wrap. Throughput: one word at a time; the next word is
//   taken once the result is registered; a result still held by the receiver
//   stalls the sequencer in its last state.
// Reset (rst_n, synchronous): pose and stored counts clear, both scales to 1.0.

module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input stream.
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // tdata: left_ticks[31:0], right_ticks[63:32], pose_x[111:64],
  //        pose_y[159:112], pose_heading[184:160], zero pad
  input  wire logic [ddo_pkg::IN_DATA_W-1:0]        in_tdata,
  // tuser: cmd
  input  wire logic                                 in_tuser,
  // Result stream.
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // tdata: pos_x[47:0], pos_y[95:48], heading[120:96], zero pad
  output logic [ddo_pkg::OUT_DATA_W-1:0]            out_tdata,
  // Configuration port.
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [2:0]                           cfg_paddr,
  input  wire logic [31:0]                          cfg_pwdata,
  output logic [31:0]                               cfg_prdata,
  output logic                                      cfg_pready
);
  import ddo_pkg::*;

  localparam int HW      = 9 + FRAC_BITS;
  localparam int V_W     = 67;
  localparam int REM_W   = 10 + FRAC_BITS;
  localparam int C_W     = FRAC_BITS + 2;
  localparam int STEPS   = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  // A full turn is 45 * 2^SH, and 2^12 is one more than a multiple of 45.
  localparam int SH      = FRAC_BITS + 3;
  localparam int FOLD_W  = 60;
  localparam int SUM_W   = 15;
  localparam int RED_W   = 13;
  localparam logic [14:0] RECIP_45 = 15'd23302;
  localparam logic [5:0]  MOD_45   = 6'd45;
  localparam longint HALF_L = 64'sd180 <<< FRAC_BITS;
  localparam longint FULL_L = 64'sd360 <<< FRAC_BITS;
  localparam logic signed [V_W-1:0]   HALF_V = V_W'(HALF_L);
  localparam logic [REM_W-1:0]        FULL_R = REM_W'(FULL_L);
  localparam logic signed [REM_W:0]   HALF_S = (REM_W+1)'(HALF_L);
  localparam logic signed [REM_W:0]   FULL_S = (REM_W+1)'(FULL_L);
  localparam logic signed [XY_W:0]    RND_Q  = (XY_W+1)'(64'sd1 <<< (29 - FRAC_BITS));
  localparam logic signed [XY_W:0]    ONE_Q  = (XY_W+1)'(64'sd1 <<< FRAC_BITS);

  // Sequencer and datapath registers.
  state_t                      state_r, state_nxt;
  logic                        cmd_r, cmd_nxt;
  logic signed [TICK_W-1:0]    dist_r, turn_r;
  logic [TICK_W-1:0]           last_l_r, last_l_nxt, last_r_r, last_r_nxt;
  logic signed [TICK_W:0]      sum_r, sum_nxt, dif_r, dif_nxt;
  logic signed [MA_W-1:0]      trav_r, trav_nxt;
  logic signed [HDG_W-1:0]     ph_r, ph_nxt;
  logic signed [HW-1:0]        heading_r, heading_nxt;
  logic [POS_W-1:0]            x_r, x_nxt, y_r, y_nxt;
  logic [V_W-1:0]              vmag_r, vmag_nxt;
  logic                        vneg_r, vneg_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [RED_W-1:0]            fold_r, fold_nxt;
  logic signed [ANG_W-1:0]     ang_r, ang_nxt;
  logic signed [XY_W-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [IDX_W-1:0]            it_r, it_nxt;
  logic                        neg_r, neg_nxt;
  logic signed [C_W-1:0]       c_r, c_nxt, s_r, s_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]            ox_r, ox_nxt, oy_r, oy_nxt;
  logic [HDG_W-1:0]            oh_r, oh_nxt;

  // Shared multiplier hookup.
  mul_ctl_t                    mul_ctl;
  mul_sts_t                    mul_sts;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [ACC_W-1:0]     mul_prod;

  // Combinational temporaries.
  logic [TICK_W-1:0]           dl, dr;
  logic signed [V_W-1:0]       v;
  logic [FOLD_W-1:0]           hi_part;
  logic [SUM_W-1:0]            chunk_sum;
  logic [RED_W-1:0]            fold_v;
  logic [27:0]                 q_full;
  logic [6:0]                  quo;
  logic [RED_W-1:0]            quo_45;
  logic [5:0]                  rem45;
  logic signed [REM_W:0]       r;
  logic signed [ANG_W-1:0]     a0;
  logic signed [XY_W-1:0]      xs, ys;
  logic signed [XY_W:0]        rx, ry, tx, ty;
  logic signed [C_W-1:0]       cq, sq;
  logic                        cfg_wr;

  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_TURN_SCALE) ? turn_r : dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= 32'sd65536;
      turn_r <= 32'sd65536;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_DIST_SCALE) begin
        dist_r <= cfg_pwdata;
      end else begin
        turn_r <= cfg_pwdata;
      end
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_ctl.start = 1'b0;
    mul_ctl.nbits = MCNT_W'(MB_W);
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      S_TRAV_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = MA_W'(sum_r);
        mul_b         = dist_r;
      end
      S_TURN_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = MA_W'(dif_r);
        mul_b         = turn_r;
      end
      S_X_GO: begin
        mul_ctl.start = 1'b1;
        mul_ctl.nbits = MCNT_W'(C_W);
        mul_a         = trav_r;
        mul_b         = MB_W'(c_r);
      end
      S_Y_GO: begin
        mul_ctl.start = 1'b1;
        mul_ctl.nbits = MCNT_W'(C_W);
        mul_a         = trav_r;
        mul_b         = MB_W'(s_r);
      end
      default: begin
        mul_ctl.start = 1'b0;
      end
    endcase
  end

  // Shared arithmetic terms.
  always_comb begin
    dl   = in_tdata[31:0] - last_l_r;
    dr   = in_tdata[63:32] - last_r_r;
    v    = cmd_r ? V_W'(ph_r) : V_W'(heading_r) + V_W'($signed(mul_prod[64:0]));
    // Whole turns above the low SH bits, folded in 12-bit chunks modulo 45.
    hi_part   = FOLD_W'(vmag_r >> SH);
    chunk_sum = SUM_W'(hi_part[11:0]) + SUM_W'(hi_part[23:12]) + SUM_W'(hi_part[35:24]) +
                SUM_W'(hi_part[47:36]) + SUM_W'(hi_part[59:48]);
    fold_v    = RED_W'(chunk_sum[11:0]) + RED_W'(chunk_sum[14:12]);
    // Quotient by 45 through a reciprocal multiply, exact for the folded range.
    q_full    = 28'(fold_r) * 28'(RECIP_45);
    quo       = q_full[26:20];
    quo_45    = RED_W'(quo) * RED_W'(MOD_45);
    rem45     = 6'(fold_r - quo_45);
    r    = (vneg_r && (rem_r != '0)) ? (FULL_S - $signed({1'b0, rem_r}))
                                     : $signed({1'b0, rem_r});
    a0   = ANG_W'(heading_r) <<< (24 - FRAC_BITS);
    xs   = cx_r >>> it_r;
    ys   = cy_r >>> it_r;
    rx   = neg_r ? -(XY_W+1)'(cx_r) : (XY_W+1)'(cx_r);
    ry   = neg_r ? -(XY_W+1)'(cy_r) : (XY_W+1)'(cy_r);
    tx   = (rx + RND_Q) >>> (30 - FRAC_BITS);
    ty   = (ry + RND_Q) >>> (30 - FRAC_BITS);
    cq   = (tx > ONE_Q) ? C_W'(ONE_Q) : ((tx < -ONE_Q) ? C_W'(-ONE_Q) : C_W'(tx));
    sq   = (ty > ONE_Q) ? C_W'(ONE_Q) : ((ty < -ONE_Q) ? C_W'(-ONE_Q) : C_W'(ty));
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    last_l_nxt    = last_l_r;
    last_r_nxt    = last_r_r;
    sum_nxt       = sum_r;
    dif_nxt       = dif_r;
    trav_nxt      = trav_r;
    ph_nxt        = ph_r;
    heading_nxt   = heading_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    vmag_nxt      = vmag_r;
    vneg_nxt      = vneg_r;
    rem_nxt       = rem_r;
    fold_nxt      = fold_r;
    ang_nxt       = ang_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    it_nxt        = it_r;
    neg_nxt       = neg_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    oh_nxt        = oh_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt = in_tuser;
          if (in_tuser == CMD_SET_POSE) begin
            x_nxt      = in_tdata[111:64];
            y_nxt      = in_tdata[159:112];
            ph_nxt     = in_tdata[184:160];
            last_l_nxt = '0;
            last_r_nxt = '0;
            state_nxt  = S_WRAP;
          end else begin
            sum_nxt    = (TICK_W+1)'($signed(dl)) + (TICK_W+1)'($signed(dr));
            dif_nxt    = (TICK_W+1)'($signed(dr)) - (TICK_W+1)'($signed(dl));
            last_l_nxt = in_tdata[31:0];
            last_r_nxt = in_tdata[63:32];
            state_nxt  = S_TRAV_GO;
          end
        end
      end
      S_TRAV_GO: state_nxt = S_TRAV_WAIT;
      S_TRAV_WAIT: begin
        if (mul_sts.done) begin
          trav_nxt  = mul_prod[64:1];
          state_nxt = S_TURN_GO;
        end
      end
      S_TURN_GO: state_nxt = S_TURN_WAIT;
      S_TURN_WAIT: begin
        if (mul_sts.done) begin
          state_nxt = S_WRAP;
        end
      end
      // New heading kept as is when in range, else reduced modulo 360.
      S_WRAP: begin
        if (v >= -HALF_V && v <= HALF_V) begin
          heading_nxt = HW'(v);
          state_nxt   = (cmd_r == CMD_SET_POSE) ? S_DONE : S_CINIT;
        end else begin
          vneg_nxt  = v[V_W-1];
          vmag_nxt  = v[V_W-1] ? V_W'(-v) : V_W'(v);
          state_nxt = S_MOD;
        end
      end
      // Fold the whole-turn part of the magnitude down to a small residue.
      S_MOD: begin
        fold_nxt  = fold_v;
        state_nxt = S_MRED;
      end
      // Residue modulo 45 joined with the low bits gives the remainder.
      S_MRED: begin
        rem_nxt   = REM_W'({rem45, vmag_r[SH-1:0]});
        state_nxt = S_MFIX;
      end
      S_MFIX: begin
        heading_nxt = (r > HALF_S) ? HW'(r - FULL_S) : HW'(r);
        state_nxt   = (cmd_r == CMD_SET_POSE) ? S_DONE : S_CINIT;
      end
      // Fold into [-90,90]; a fold by 180 degrees negates both results.
      S_CINIT: begin
        cx_nxt  = GAIN_Q30;
        cy_nxt  = '0;
        it_nxt  = '0;
        neg_nxt = 1'b0;
        ang_nxt = a0;
        if (a0 > D90_Q24) begin
          ang_nxt = a0 - (D90_Q24 <<< 1);
          neg_nxt = 1'b1;
        end else if (a0 < -D90_Q24) begin
          ang_nxt = a0 + (D90_Q24 <<< 1);
          neg_nxt = 1'b1;
        end
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        if (!ang_r[ANG_W-1]) begin
          cx_nxt  = cx_r - ys;
          cy_nxt  = cy_r + xs;
          ang_nxt = ang_r - ANG_W'(ATAN_Q24[it_r]);
        end else begin
          cx_nxt  = cx_r + ys;
          cy_nxt  = cy_r - xs;
          ang_nxt = ang_r + ANG_W'(ATAN_Q24[it_r]);
        end
        it_nxt = it_r + 1'b1;
        if (it_r == IDX_W'(STEPS - 1)) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        c_nxt     = cq;
        s_nxt     = sq;
        state_nxt = S_X_GO;
      end
      S_X_GO: state_nxt = S_X_WAIT;
      S_X_WAIT: begin
        if (mul_sts.done) begin
          x_nxt     = x_r + mul_prod[FRAC_BITS+POS_W-1:FRAC_BITS];
          state_nxt = S_Y_GO;
        end
      end
      S_Y_GO: state_nxt = S_Y_WAIT;
      S_Y_WAIT: begin
        if (mul_sts.done) begin
          y_nxt     = y_r + mul_prod[FRAC_BITS+POS_W-1:FRAC_BITS];
          state_nxt = S_DONE;
        end
      end
      // Hand the pose to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          ox_nxt        = x_r;
          oy_nxt        = y_r;
          oh_nxt        = HDG_W'(heading_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pose state, stored counts and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_l_r    <= '0;
      last_r_r    <= '0;
      heading_r   <= '0;
      x_r         <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      last_l_r    <= last_l_nxt;
      last_r_r    <= last_r_nxt;
      heading_r   <= heading_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    sum_r  <= sum_nxt;
    dif_r  <= dif_nxt;
    trav_r <= trav_nxt;
    ph_r   <= ph_nxt;
    vmag_r <= vmag_nxt;
    vneg_r <= vneg_nxt;
    rem_r  <= rem_nxt;
    fold_r <= fold_nxt;
    ang_r  <= ang_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    it_r   <= it_nxt;
    neg_r  <= neg_nxt;
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oh_r   <= oh_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, oh_r, oy_r, ox_r};

  // The multiplier only finishes while the sequencer waits for it.
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == S_TRAV_WAIT || state_r == S_TURN_WAIT ||
                      state_r == S_X_WAIT || state_r == S_Y_WAIT))
    else $error("multiplier finished outside a wait state");

  // The stored heading stays within [-180,180] degrees.
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (heading_r >= HW'(-HALF_L) && heading_r <= HW'(HALF_L)))
    else $error("heading outside range");

  // The reduced remainder stays below one full turn.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MFIX) |-> (rem_r < FULL_R))
    else $error("modulo remainder out of bound");

  // The rounded cosine is clamped to [-1,1].
  a_cos_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_X_GO) |-> (c_r <= C_W'(ONE_Q) && c_r >= C_W'(-ONE_Q)))
    else $error("cosine out of unit range");

  // No new word is taken while one is in flight.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE))
    else $error("ready outside idle");

endmodule
`default_nettype wire
